/* sv/dpwm_pkg.sv */
// Shared types, codes and constants of the dual PWM H-bridge motor drive.
// No dependencies; every other file imports this package.
package dpwm_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int PERIOD_W        = 16;
    localparam int TRIM_W          = 7;
    localparam int PCT_W           = 7;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [TRIM_W-1:0]   TRIM_RESET   = 7'd90;
    localparam logic [PCT_W-1:0]    PCT_FULL     = 7'd100;

    // request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_CMD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // motor select
    localparam logic [1:0] SEL_LEFT  = 2'd0;
    localparam logic [1:0] SEL_RIGHT = 2'd1;
    localparam logic [1:0] SEL_BOTH  = 2'd2;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    // direction codes
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BWD   = 2'd1;
    localparam logic [1:0] DIR_BRAKE = 2'd2;
    localparam logic [1:0] DIR_KEEP  = 2'd3;

    // configuration register indexes
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_TRIM   = 1'b1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [1:0]       motor_select;
        logic [PCT_W-1:0] speed_percent;
        logic [1:0]       direction;
    } t_in;

    typedef struct packed {
        logic             left_enable;
        logic             right_enable;
        logic             left_in_a;
        logic             left_in_b;
        logic             right_in_a;
        logic             right_in_b;
        logic [1:0]       queried_direction;
        logic [PCT_W-1:0] queried_speed;
    } t_out;

    // classified item as queued between front and back
    typedef struct packed {
        logic [1:0]       op;
        logic             set_left;
        logic             set_right;
        logic             query_right;
        logic             dir_wr;
        logic [1:0]       dir;
        logic [PCT_W-1:0] spd;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    function automatic t_out mk_out(input logic l_lvl, input logic r_lvl,
                                    input logic [1:0] l_dir, input logic [1:0] r_dir,
                                    input logic [1:0] qdir, input logic [PCT_W-1:0] qspd);
        t_out o;
        o.left_enable       = l_lvl;
        o.right_enable      = r_lvl;
        o.left_in_a         = (l_dir == DIR_FWD) || (l_dir == DIR_BRAKE);
        o.left_in_b         = (l_dir == DIR_BWD) || (l_dir == DIR_BRAKE);
        o.right_in_a        = (r_dir == DIR_FWD) || (r_dir == DIR_BRAKE);
        o.right_in_b        = (r_dir == DIR_BWD) || (r_dir == DIR_BRAKE);
        o.queried_direction = qdir;
        o.queried_speed     = qspd;
        return o;
    endfunction

endpackage

/* sv/dual_pwm_hbridge_motor_drive.sv */
// Top level of the dual PWM H-bridge motor drive: configuration registers,
// front end, item queue and back end. Depends on dpwm_pkg and all dpwm_ modules.
//
// Channels: a request channel (i_in_valid/o_in_ready, i_in_data) carrying ticks,
// motor commands and queries; a result channel (o_out_valid/i_out_ready,
// o_out_data) giving one result per request with the enable and bridge input
// levels after the request, plus the queried direction and speed; and a
// configuration write channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
// that is always ready: index 0 the PWM period, index 1 the left trim percent.
// A tick, a no-op request or a saturated query is answered from the result
// register, and ticks sustain one per cycle while the receiver is ready and
// the back end is idle. A command multiplies the period by the speed and
// divides by 100, then, when it sets the left motor, applies the trim the
// same way (the divides by 100 are reciprocal multiplies). An unsaturated
// query runs PW = max(COUNT_WIDTH, 16) + 7 steps of a bit-serial divider.
// A four-entry queue sits between the front and back ends, so requests keep
// being taken while the back end divides or the receiver stalls; the result
// register holds its value until taken, and when the queue fills o_in_ready
// drops. Reset brings the period to 1000, the trim to 90, both motors to
// brake with enables low and zero high time.
module dual_pwm_hbridge_motor_drive #(
    parameter int COUNT_WIDTH = dpwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dpwm_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dpwm_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [dpwm_pkg::PERIOD_W-1:0]  i_cfg_data
);
    import dpwm_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [TRIM_W-1:0]   r_trim;
    logic                full;
    logic                push;
    t_item               push_item;
    logic                pop;
    t_head               head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_trim   <= TRIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_TRIM:   r_trim   <= i_cfg_data[TRIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dpwm_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_full      (full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    dpwm_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (full),
        .i_pop       (pop),
        .o_head      (head)
    );

    dpwm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_period),
        .i_trim      (r_trim),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* sv/dpwm_front.sv */
// Front end: accepts request transfers, saturates speed and decodes selects.
// Depends on dpwm_pkg.
module dpwm_front (
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dpwm_pkg::t_in    i_in_data,
    input  logic             i_full,
    output logic             o_push,
    output dpwm_pkg::t_item  o_push_item
);
    import dpwm_pkg::*;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_push_item             = '0;
        o_push_item.op          = i_in_data.req_type;
        o_push_item.spd         = (i_in_data.speed_percent > PCT_FULL) ?
                                  PCT_FULL : i_in_data.speed_percent;
        o_push_item.dir         = i_in_data.direction;
        o_push_item.dir_wr      = (i_in_data.direction != DIR_KEEP);
        o_push_item.query_right = (i_in_data.motor_select == SEL_RIGHT);
        case (i_in_data.motor_select)
            SEL_LEFT: begin
                o_push_item.set_left = 1'b1;
            end
            SEL_RIGHT: begin
                o_push_item.set_right = 1'b1;
            end
            SEL_BOTH: begin
                o_push_item.set_left  = 1'b1;
                o_push_item.set_right = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/dpwm_fifo.sv */
// Short queue of classified items between the front and back ends.
// Depends on dpwm_pkg.
module dpwm_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpwm_pkg::t_item  i_push_item,
    output logic             o_full,
    input  logic             i_pop,
    output dpwm_pkg::t_head  o_head
);
    import dpwm_pkg::*;

    localparam int AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNW = $clog2(FIFO_DEPTH + 1);

    t_item          r_mem [FIFO_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CNW-1:0] r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full          = (r_count == CNW'(FIFO_DEPTH));
    assign o_head.valid    = (r_count != '0);
    assign o_head.item     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNW'(1);
                2'b01:   r_count <= r_count - CNW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/dpwm_back.sv */
// Back end: PWM channel state, tick handling, command and query execution
// (reciprocal multiply for the divides by 100, bit-serial divider for queries)
// and the result register. Depends on dpwm_pkg.
module dpwm_back #(
    parameter int COUNT_WIDTH = dpwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dpwm_pkg::PERIOD_W-1:0]  i_period,
    input  logic [dpwm_pkg::TRIM_W-1:0]    i_trim,
    input  dpwm_pkg::t_head                i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dpwm_pkg::t_out                 o_out_data
);
    import dpwm_pkg::*;

    localparam int CW  = COUNT_WIDTH;
    localparam int WW  = (CW > PERIOD_W) ? CW : PERIOD_W;
    localparam int PW  = (CW + PCT_W > PERIOD_W + PCT_W) ? CW + PCT_W : PERIOD_W + PCT_W;
    localparam int DCW = $clog2(PW + 1);
    localparam logic [CW-1:0] CNT_MAX   = '1;
    localparam logic [CW-1:0] RLD_RESET = (WW'(PERIOD_RESET) > WW'(CNT_MAX)) ?
                                          CNT_MAX : CW'(PERIOD_RESET);

    // x / 100 as (x * ceil(2^30 / 100)) >> 30, exact for any x below 2^23
    localparam int MW  = PERIOD_W + PCT_W;
    localparam int RW  = 24;
    localparam int RSH = 30;
    localparam int QW  = MW + RW - RSH;
    localparam logic [RW-1:0] RECIP_100 = 24'd10737419;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV_HT   = 3'd1;
    localparam logic [2:0] S_MUL_TRIM = 3'd2;
    localparam logic [2:0] S_DIV_TRIM = 3'd3;
    localparam logic [2:0] S_DIV_QRY  = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_l_ht, r_r_ht, r_l_cnt, r_r_cnt, r_l_rld, r_r_rld;
    logic                r_l_lvl, r_r_lvl;
    logic [1:0]          r_l_dir, r_r_dir;
    t_item               r_item;
    logic [CW-1:0]       r_ht;
    logic [1:0]          r_qdir;
    logic [PCT_W-1:0]    r_qspd;
    logic [PW-1:0]       r_quo;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_dvs;
    logic [DCW-1:0]      r_dcnt;
    t_out                r_out;
    logic                r_out_valid;

    logic                slot_free;
    logic [2*CW:0]       n_l_tick, n_r_tick;
    logic [CW-1:0]       q_ht;
    logic [1:0]          q_dir;
    logic                per_zero, q_full, q_now;
    logic [PERIOD_W:0]   rem_sh, rem_diff;
    logic                rem_ge;
    logic [PERIOD_W-1:0] n_rem;
    logic [PW-1:0]       n_quo;
    logic                div_last;
    logic [MW+RW-1:0]    recip_prod;
    logic [QW-1:0]       div100;
    logic [CW-1:0]       ht_sat;
    logic [TRIM_W-1:0]   trim_sat;

    function automatic logic [CW-1:0] sat_cnt(input logic [PW-1:0] v);
        return (v > PW'(CNT_MAX)) ? CNT_MAX : v[CW-1:0];
    endfunction

    // returns {level, reload, countdown} after one tick
    function automatic logic [2*CW:0] tick_ch(input logic [CW-1:0] ht,
                                              input logic [CW-1:0] cnt,
                                              input logic [CW-1:0] rld,
                                              input logic lvl,
                                              input logic [PERIOD_W-1:0] per);
        logic [CW-1:0] rld_nx;
        logic          lvl_nx;
        logic [WW-1:0] diff;
        rld_nx = rld;
        lvl_nx = lvl;
        diff   = WW'(per) - WW'(ht);
        if (cnt != '0) begin
            return {lvl, rld, cnt - CW'(1)};
        end
        if (lvl) begin
            lvl_nx = 1'b0;
            if (WW'(ht) >= WW'(per)) begin
                rld_nx = '0;
            end else begin
                rld_nx = (diff > WW'(CNT_MAX)) ? CNT_MAX : diff[CW-1:0];
            end
        end else if (ht != '0) begin
            lvl_nx = 1'b1;
            rld_nx = ht;
        end
        return {lvl_nx, rld_nx, (rld_nx != '0) ? rld_nx - CW'(1) : CW'(0)};
    endfunction

    always_comb begin
        slot_free = !r_out_valid || i_out_ready;
        n_l_tick  = tick_ch(r_l_ht, r_l_cnt, r_l_rld, r_l_lvl, i_period);
        n_r_tick  = tick_ch(r_r_ht, r_r_cnt, r_r_rld, r_r_lvl, i_period);
        q_ht      = i_head.item.query_right ? r_r_ht : r_l_ht;
        q_dir     = i_head.item.query_right ? r_r_dir : r_l_dir;
        per_zero  = (i_period == '0);
        q_full    = (WW'(q_ht) >= WW'(i_period));
        q_now     = per_zero || q_full;
        trim_sat  = (i_trim > PCT_FULL) ? PCT_FULL : i_trim;

        // one restoring division step
        rem_sh    = {r_rem, r_quo[PW-1]};
        rem_diff  = rem_sh - {1'b0, r_dvs};
        rem_ge    = (rem_sh >= {1'b0, r_dvs});
        n_rem     = rem_ge ? rem_diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        n_quo     = {r_quo[PW-2:0], rem_ge};
        div_last  = (r_dcnt == DCW'(1));

        recip_prod = (MW+RW)'(r_quo[MW-1:0]) * (MW+RW)'(RECIP_100);
        div100     = recip_prod[MW+RW-1:RSH];
        ht_sat     = sat_cnt(PW'(div100));

        o_pop = 1'b0;
        if (r_state == S_IDLE && i_head.valid) begin
            case (i_head.item.op)
                REQ_TICK, REQ_NOP: o_pop = slot_free;
                REQ_QUERY:         o_pop = !q_now || slot_free;
                REQ_CMD:           o_pop = 1'b1;
                default:           o_pop = 1'b0;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_l_ht      <= '0;
            r_r_ht      <= '0;
            r_l_cnt     <= '0;
            r_r_cnt     <= '0;
            r_l_rld     <= RLD_RESET;
            r_r_rld     <= RLD_RESET;
            r_l_lvl     <= 1'b0;
            r_r_lvl     <= 1'b0;
            r_l_dir     <= DIR_BRAKE;
            r_r_dir     <= DIR_BRAKE;
            r_dcnt      <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.item.op)
                            REQ_TICK: begin
                                {r_l_lvl, r_l_rld, r_l_cnt} <= n_l_tick;
                                {r_r_lvl, r_r_rld, r_r_cnt} <= n_r_tick;
                                r_out <= mk_out(n_l_tick[2*CW], n_r_tick[2*CW],
                                                r_l_dir, r_r_dir, 2'd0, '0);
                                r_out_valid <= 1'b1;
                            end
                            REQ_NOP: begin
                                r_out <= mk_out(r_l_lvl, r_r_lvl, r_l_dir, r_r_dir,
                                                2'd0, '0);
                                r_out_valid <= 1'b1;
                            end
                            REQ_QUERY: begin
                                r_qdir <= q_dir;
                                if (q_now) begin
                                    r_out <= mk_out(r_l_lvl, r_r_lvl, r_l_dir, r_r_dir,
                                                    q_dir, per_zero ? PCT_W'(0) : PCT_FULL);
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_quo   <= PW'(q_ht) * PW'(PCT_FULL);
                                    r_rem   <= '0;
                                    r_dvs   <= i_period;
                                    r_dcnt  <= DCW'(PW);
                                    r_state <= S_DIV_QRY;
                                end
                            end
                            REQ_CMD: begin
                                r_item  <= i_head.item;
                                r_quo   <= PW'(i_period) * PW'(i_head.item.spd);
                                r_state <= S_DIV_HT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV_HT: begin
                    if (r_item.set_right) begin
                        r_r_ht <= ht_sat;
                        if (r_item.dir_wr) begin
                            r_r_dir <= r_item.dir;
                        end
                    end
                    if (r_item.set_left && r_item.dir_wr) begin
                        r_l_dir <= r_item.dir;
                    end
                    r_ht    <= ht_sat;
                    r_qdir  <= 2'd0;
                    r_qspd  <= '0;
                    r_state <= r_item.set_left ? S_MUL_TRIM : S_FINISH;
                end
                S_MUL_TRIM: begin
                    r_quo   <= PW'(r_ht) * PW'(trim_sat);
                    r_state <= S_DIV_TRIM;
                end
                S_DIV_TRIM: begin
                    // trimmed time never exceeds the untrimmed one
                    r_l_ht  <= CW'(div100);
                    r_state <= S_FINISH;
                end
                S_DIV_QRY: begin
                    r_quo  <= n_quo;
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (div_last) begin
                        r_qspd  <= n_quo[PCT_W-1:0];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_out <= mk_out(r_l_lvl, r_r_lvl, r_l_dir, r_r_dir, r_qdir, r_qspd);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
